// File: hw/rtl/rpn_pkg.sv
`timescale 1ns / 1ps
package rpn_pkg;

  localparam int QW = 32;
  localparam int DVW = 48;

  typedef logic [3:0] op_t;

  localparam op_t OP_NUM   = 4'd0;
  localparam op_t OP_ADD   = 4'd1;
  localparam op_t OP_MUL   = 4'd2;
  localparam op_t OP_SUB   = 4'd3;
  localparam op_t OP_DIV   = 4'd4;
  localparam op_t OP_PRINT = 4'd5;
  localparam op_t OP_DUP   = 4'd6;
  localparam op_t OP_SWAP  = 4'd7;
  localparam op_t OP_MOD   = 4'd8;
  localparam op_t OP_END   = 4'd9;
  localparam op_t OP_UNK   = 4'd10;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] number_value;
  } in_t;

  typedef struct packed {
    logic               shown_valid;
    logic signed [31:0] shown_first;
    logic signed [31:0] shown_second;
    logic               err_stack_empty;
    logic               err_stack_full;
    logic               err_zero_divisor;
    logic               err_unknown;
    logic               err_overflow;
    logic [7:0]         stack_depth;
  } out_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [DVW-1:0]   dividend;
    logic [QW-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVW-1:0]   quotient;
    logic [QW-1:0]    remainder;
  } div_rsp_t;

endpackage

// File: hw/rtl/rpn_ram.sv
`timescale 1ns / 1ps
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rpn_div.sv
`timescale 1ns / 1ps
module rpn_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::div_req_t req,
  output rpn_pkg::div_rsp_t rsp
);
  import rpn_pkg::*;

  localparam int CW = $clog2(DVW + 1);

  logic [QW-1:0]  rem_r, rem_nxt;
  logic [DVW-1:0] quo_r, quo_nxt;
  logic [QW-1:0]  dvs_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [QW:0]    trial;

  // one restoring step per cycle, dividend shifts out as quotient shifts in
  always_comb begin
    trial    = {rem_r, quo_r[DVW-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = QW'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DVW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[QW-1:0];
        quo_nxt = {quo_r[DVW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DVW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// File: hw/rtl/rpn_front.sv
`timescale 1ns / 1ps
module rpn_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  rpn_pkg::in_t  in_data,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output rpn_pkg::cmd_t cmd
);
  import rpn_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cls;
  logic       wr, rd;

  // fold every undefined selector onto the unknown command
  always_comb begin
    cls.value = in_data.number_value;
    cls.op    = (in_data.req_type > OP_END) ? OP_UNK : in_data.req_type;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign wr        = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign rd        = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// File: hw/rtl/rpn_back.sv
`timescale 1ns / 1ps
module rpn_back #(
  parameter int STACK_DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  rpn_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rpn_pkg::out_t rsp
);
  import rpn_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POP1 = 4'd1;
  localparam logic [3:0] S_CAP1 = 4'd2;
  localparam logic [3:0] S_POP2 = 4'd3;
  localparam logic [3:0] S_CAP2 = 4'd4;
  localparam logic [3:0] S_EXEC = 4'd5;
  localparam logic [3:0] S_MULS = 4'd6;
  localparam logic [3:0] S_DIVW = 4'd7;
  localparam logic [3:0] S_PUSH = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  function automatic logic [32:0] sat32(input logic [48:0] v);
    if (v[48:31] == '0 || v[48:31] == '1) begin
      return {1'b0, v[31:0]};
    end else if (v[48]) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b1, 32'h7FFF_FFFF};
    end
  endfunction

  // integer part, truncated toward zero
  function automatic logic [16:0] q_trunc(input logic [31:0] x);
    logic [16:0] hi;
    hi = {x[31], x[31:16]};
    if (x[31] && x[15:0] != 16'h0) begin
      hi = hi + 17'd1;
    end
    return hi;
  endfunction

  logic [3:0]         state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [31:0]        p1_r, p1_nxt;
  logic [31:0]        p2_r, p2_nxt;
  logic [31:0]        res_r, res_nxt;
  logic signed [63:0] prod_r;
  logic [SPW-1:0]     sp_r, sp_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               f_emp_r, f_emp_nxt;
  logic               f_full_r, f_full_nxt;
  logic               f_zero_r, f_zero_nxt;
  logic               f_ovf_r, f_ovf_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [1:0]         npush_r, npush_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  logic [SPW-1:0]     sp_m1;
  logic [31:0]        val;
  logic [16:0]        ai, bi, ai_mag, bi_mag;
  logic [31:0]        p1_mag, p2_mag;
  logic               neg;
  logic [48:0]        qx, sq;
  logic [15:0]        r16;
  logic [32:0]        s33;
  logic [32:0]        sat;
  logic               can_push;
  div_req_t           dreq;
  div_rsp_t           drsp;

  rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign sp_m1     = sp_r - 1'b1;
  assign ram_raddr = sp_m1[AW-1:0];
  assign ram_waddr = sp_r[AW-1:0];
  assign can_push  = (sp_r < SPW'(STACK_DEPTH));
  assign ram_wdata = (op_r == OP_SWAP && idx_r != 2'd0) ? p2_r : res_r;
  assign ram_we    = (state_r == S_PUSH) && (idx_r != npush_r) && can_push;
  assign val       = rd_ok_r ? ram_rdata : 32'h0;

  assign ai     = q_trunc(p2_r);
  assign bi     = q_trunc(p1_r);
  assign ai_mag = ai[16] ? (~ai + 17'd1) : ai;
  assign bi_mag = bi[16] ? (~bi + 17'd1) : bi;
  assign p1_mag = p1_r[31] ? (~p1_r + 32'd1) : p1_r;
  assign p2_mag = p2_r[31] ? (~p2_r + 32'd1) : p2_r;
  assign neg    = p1_r[31] ^ p2_r[31];
  assign qx     = {1'b0, drsp.quotient};
  assign sq     = neg ? (~qx + 49'd1) : qx;
  assign r16    = ai[16] ? (~drsp.remainder[15:0] + 16'd1) : drsp.remainder[15:0];

  always_comb begin
    dreq.start    = (state_r == S_EXEC) && (op_r == OP_DIV || op_r == OP_MOD);
    dreq.dividend = (op_r == OP_MOD) ? DVW'(ai_mag) : {p2_mag, 16'h0};
    dreq.divisor  = (op_r == OP_MOD) ? QW'(bi_mag) : p1_mag;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    res_nxt    = res_r;
    sp_nxt     = sp_r;
    rd_ok_nxt  = rd_ok_r;
    f_emp_nxt  = f_emp_r;
    f_full_nxt = f_full_r;
    f_zero_nxt = f_zero_r;
    f_ovf_nxt  = f_ovf_r;
    idx_nxt    = idx_r;
    npush_nxt  = npush_r;
    s33        = '0;
    sat        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          op_nxt     = cmd.op;
          res_nxt    = cmd.value;
          f_emp_nxt  = 1'b0;
          f_full_nxt = 1'b0;
          f_zero_nxt = 1'b0;
          f_ovf_nxt  = 1'b0;
          idx_nxt    = 2'd0;
          npush_nxt  = 2'd1;
          if (cmd.op == OP_NUM) begin
            state_nxt = S_PUSH;
          end else if (cmd.op == OP_UNK) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_POP1;
          end
        end
      end
      S_POP1, S_POP2: begin
        if (sp_r != '0) begin
          sp_nxt    = sp_m1;
          rd_ok_nxt = 1'b1;
        end else begin
          rd_ok_nxt = 1'b0;
          f_emp_nxt = 1'b1;
        end
        state_nxt = (state_r == S_POP1) ? S_CAP1 : S_CAP2;
      end
      S_CAP1: begin
        p1_nxt  = val;
        res_nxt = val;
        unique case (op_r) inside
          OP_ADD, OP_MUL, OP_SUB, OP_SWAP: begin
            state_nxt = S_POP2;
          end
          OP_DIV: begin
            if (val == 32'h0) begin
              f_zero_nxt = 1'b1;
              state_nxt  = S_FIN;
            end else begin
              state_nxt = S_POP2;
            end
          end
          OP_MOD: begin
            if (q_trunc(val) == 17'h0) begin
              f_zero_nxt = 1'b1;
              state_nxt  = S_FIN;
            end else begin
              state_nxt = S_POP2;
            end
          end
          OP_PRINT: begin
            npush_nxt = 2'd2;
            state_nxt = S_PUSH;
          end
          OP_DUP: begin
            npush_nxt = 2'd3;
            state_nxt = S_PUSH;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_CAP2: begin
        p2_nxt    = val;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_r) inside
          OP_ADD, OP_SUB: begin
            if (op_r == OP_ADD) begin
              s33 = {p2_r[31], p2_r} + {p1_r[31], p1_r};
            end else begin
              s33 = {p2_r[31], p2_r} - {p1_r[31], p1_r};
            end
            sat        = sat32({{16{s33[32]}}, s33});
            res_nxt    = sat[31:0];
            f_ovf_nxt  = sat[32];
            state_nxt  = S_PUSH;
          end
          OP_MUL: begin
            state_nxt = S_MULS;
          end
          OP_DIV, OP_MOD: begin
            state_nxt = S_DIVW;
          end
          default: begin
            npush_nxt = 2'd3;
            state_nxt = S_PUSH;
          end
        endcase
      end
      S_MULS: begin
        // dropping the low 16 bits of a two's complement product rounds down
        sat       = sat32({prod_r[63], prod_r[63:16]});
        res_nxt   = sat[31:0];
        f_ovf_nxt = sat[32];
        state_nxt = S_PUSH;
      end
      S_DIVW: begin
        if (drsp.done) begin
          if (op_r == OP_MOD) begin
            res_nxt = {r16, 16'h0};
          end else begin
            sat       = sat32(sq);
            res_nxt   = sat[31:0];
            f_ovf_nxt = sat[32];
          end
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (idx_r == npush_r) begin
          state_nxt = S_FIN;
        end else begin
          if (can_push) begin
            sp_nxt = sp_r + 1'b1;
          end else begin
            f_full_nxt = 1'b1;
          end
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_FIN: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
    end
    op_r     <= op_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    res_r    <= res_nxt;
    rd_ok_r  <= rd_ok_nxt;
    f_emp_r  <= f_emp_nxt;
    f_full_r <= f_full_nxt;
    f_zero_r <= f_zero_nxt;
    f_ovf_r  <= f_ovf_nxt;
    idx_r    <= idx_nxt;
    npush_r  <= npush_nxt;
    prod_r   <= $signed(p1_r) * $signed(p2_r);
  end

  logic shown;
  assign shown = (op_r == OP_PRINT) || (op_r == OP_DUP) || (op_r == OP_SWAP)
              || (op_r == OP_END);

  assign cmd_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_FIN);

  always_comb begin
    rsp.shown_valid      = shown;
    rsp.shown_first      = !shown ? 32'h0 : (op_r == OP_SWAP) ? p2_r : p1_r;
    rsp.shown_second     = (op_r == OP_SWAP || op_r == OP_DUP) ? p1_r : 32'h0;
    rsp.err_stack_empty  = f_emp_r;
    rsp.err_stack_full   = f_full_r;
    rsp.err_zero_divisor = f_zero_r;
    rsp.err_unknown      = (op_r == OP_UNK);
    rsp.err_overflow     = f_ovf_r;
    rsp.stack_depth      = 8'(sp_r);
  end

endmodule

// File: hw/rtl/rpn_stack_calculator_top.sv
`timescale 1ns / 1ps
// rpn calculator over signed Q16.16 values, one token in, one result out
// input queue: drive in_data and raise in_push; the token is taken on a
//   clock edge with in_push high and in_full low; two tokens can wait
// result queue: while out_empty is low the oldest result is on out_data;
//   it is taken on a clock edge with out_pop high
// a token is sequenced by one stack memory access per cycle for each pop
//   and push, through the pop, capture and push states
// divide and modulo wait in S_DIVW for the bit-serial divider
//   (48 quotient bits, one per cycle)
// multiply adds the S_MULS state for the registered product
// one token is in the sequencer at a time; the next one starts the cycle
//   after the previous result moves into the result register
// synchronous active-low reset empties both queues and the stack; stack
//   memory contents are not cleared, only the depth count
// if out_pop stays low the finished result is held, the sequencer waits
//   and the input queue fills until in_full rises
module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  rpn_pkg::in_t  in_data,
  output logic          out_empty,
  input  logic          out_pop,
  output rpn_pkg::out_t out_data
);
  import rpn_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic rsp_valid, rsp_ready;
  out_t rsp;
  logic ovalid_r;
  out_t odata_r;

  rpn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  rpn_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign rsp_ready = !ovalid_r || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (rsp_ready) begin
      ovalid_r <= rsp_valid;
    end
    if (rsp_ready && rsp_valid) begin
      odata_r <= rsp;
    end
  end

  assign out_empty = !ovalid_r;
  assign out_data  = odata_r;

endmodule

// File: hw/rtl/rpn_checker.sv
`timescale 1ns / 1ps
module rpn_props (
  input logic          clk,
  input logic          rst_n,
  input logic          in_full,
  input logic          out_empty,
  input logic          out_pop,
  input rpn_pkg::out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed before pop");

  a_shown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_data.shown_valid |-> out_data.shown_first == 32'h0)
    else $error("shown value without display");

  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.err_unknown |->
      !out_data.shown_valid && !out_data.err_overflow && !out_data.err_zero_divisor
      && !out_data.err_stack_empty && !out_data.err_stack_full)
    else $error("unknown command reported other faults");

endmodule

bind rpn_stack_calculator_top rpn_props u_rpn_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
